// ----- rtl/core/wbpd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the WAH bitmap position decoder.
// Used by the controller, the datapath, the top level and the checker.
package wbpd_pkg;

	localparam int WORD_W    = 32;
	localparam int PAYLOAD_W = 31;
	localparam int COUNT_W   = 30;
	localparam int POS_W     = 48;
	localparam int RUN_W     = 35;
	localparam int TZ_W      = 5;

	localparam int LITERAL_FLAG = 31;
	localparam int ONEFILL_FLAG = 30;

	localparam logic [POS_W-1:0] WORD_BITS = POS_W'(31);

	localparam logic KIND_SINGLE = 1'b0;
	localparam logic KIND_RUN    = 1'b1;

	typedef struct packed {
		logic load;
		logic emit;
	} wbpd_cmd_t;

	typedef struct packed {
		logic in_has_result;
		logic emit_last;
		logic out_free;
	} wbpd_status_t;

	function automatic logic [TZ_W-1:0] lowest_set(input logic [PAYLOAD_W-1:0] v);
		logic [TZ_W-1:0] n;
		n = '0;
		for (int i = PAYLOAD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = TZ_W'(i);
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/wah_bitmap_position_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the WAH bitmap position decoder: controller plus datapath.
// Depends on wbpd_pkg, wbpd_ctrl and wbpd_dp.

// The block takes one 32-bit WAH word per item and returns the positions of its set
// bits. A literal with k set payload bits gives k single-bit results, one per cycle
// while the output is not stalled, lowest bit first, and a nonzero one-fill gives one
// run result; the input stays stalled until the last result of a word has gone into the
// single output register, which the pending payload feeds one result at a time.
// Zero-fills, empty literals and zero-length one-fills give no result and do not stall
// the input. The next word is taken while the last result of the previous one still
// waits in the output register.
module wah_bitmap_position_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wbpd_pkg::WORD_W-1:0]    word,
	input  logic                           first_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           kind,
	output logic [wbpd_pkg::POS_W-1:0]     position,
	output logic [wbpd_pkg::RUN_W-1:0]     run_length,
	output logic                           last
);
	import wbpd_pkg::*;

	wbpd_cmd_t    cmd;
	wbpd_status_t status;

	wbpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	wbpd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.word       (word),
		.first_word (first_word),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.kind       (kind),
		.position   (position),
		.run_length (run_length),
		.last       (last)
	);

endmodule

// ----- rtl/core/wbpd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the WAH bitmap position decoder.
// Depends on wbpd_pkg for the command and status structs.
module wbpd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  wbpd_pkg::wbpd_status_t  status,
	output wbpd_pkg::wbpd_cmd_t     cmd
);
	import wbpd_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid && status.in_has_result) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = status.out_free;
				if (status.out_free && status.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/wbpd_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the WAH bitmap position decoder: running position, pending payload
// and the output register. Depends on wbpd_pkg.
module wbpd_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wbpd_pkg::wbpd_cmd_t                  cmd,
	output wbpd_pkg::wbpd_status_t               status,
	input  logic [wbpd_pkg::WORD_W-1:0]          word,
	input  logic                                 first_word,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic                                 kind,
	output logic [wbpd_pkg::POS_W-1:0]           position,
	output logic [wbpd_pkg::RUN_W-1:0]           run_length,
	output logic                                 last
);
	import wbpd_pkg::*;

	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     base_q;
	logic [PAYLOAD_W-1:0] pend_q;
	logic                 fill_q;
	logic [RUN_W-1:0]     range_q;
	logic                 out_valid_q;
	logic                 kind_q;
	logic [POS_W-1:0]     position_q;
	logic [RUN_W-1:0]     run_length_q;
	logic                 last_q;

	logic                 is_literal;
	logic [COUNT_W-1:0]   count;
	logic [RUN_W-1:0]     range;
	logic [POS_W-1:0]     pos_start;
	logic [POS_W-1:0]     advance;
	logic [TZ_W-1:0]      tz;
	logic [PAYLOAD_W-1:0] rest;

	assign is_literal = word[LITERAL_FLAG];
	assign count      = word[COUNT_W-1:0];
	assign range      = {count, 5'b00000} - {5'b00000, count};
	assign pos_start  = first_word ? '0 : pos_q;
	assign advance    = is_literal ? WORD_BITS : {{(POS_W - RUN_W){1'b0}}, range};

	assign tz   = lowest_set(pend_q);
	assign rest = pend_q & (pend_q - PAYLOAD_W'(1));

	assign status.in_has_result = is_literal ? (word[PAYLOAD_W-1:0] != '0)
	                                         : (word[ONEFILL_FLAG] && (count != '0));
	assign status.emit_last     = fill_q || (rest == '0);
	assign status.out_free      = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pos_q <= pos_start + advance;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= pos_start;
			pend_q  <= word[PAYLOAD_W-1:0];
			fill_q  <= !is_literal;
			range_q <= range;
		end else if (cmd.emit && !fill_q) begin
			pend_q <= rest;
		end
		if (cmd.emit) begin
			if (fill_q) begin
				kind_q       <= KIND_RUN;
				position_q   <= base_q;
				run_length_q <= range_q;
				last_q       <= 1'b1;
			end else begin
				kind_q       <= KIND_SINGLE;
				position_q   <= base_q + {{(POS_W - TZ_W){1'b0}}, tz};
				run_length_q <= RUN_W'(1);
				last_q       <= (rest == '0);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign position   = position_q;
	assign run_length = run_length_q;
	assign last       = last_q;

endmodule

// ----- rtl/core/wbpd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the WAH bitmap position decoder, bound to the top level.
// Depends on wbpd_pkg.
module wbpd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [wbpd_pkg::WORD_W-1:0]    word,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           kind,
	input logic [wbpd_pkg::POS_W-1:0]     position,
	input logic [wbpd_pkg::RUN_W-1:0]     run_length,
	input logic                           last
);
	import wbpd_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(kind)
			&& $stable(run_length) && $stable(last))
		else $error("Stalled output item changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !word[LITERAL_FLAG] && !word[ONEFILL_FLAG] |=> !in_stall)
		else $error("A zero-fill item left the input stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_RUN) |-> last && (run_length != '0))
		else $error("A run item is not marked last or has zero length.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_SINGLE) |-> (run_length == RUN_W'(1)))
		else $error("A single-bit item has a length other than one.");

endmodule

bind wah_bitmap_position_decoder wbpd_checker u_wbpd_checker (.*);
